>>> hdl/osp_pkg.sv
// shared types and constants of the ordered set predecessor claim block
// no dependencies
package osp_pkg;

	localparam int unsigned CAPACITY_DEF = 1024;
	localparam int unsigned POS_W        = 30;
	localparam int unsigned TOTAL_W      = 48;
	localparam int unsigned STATUS_W     = 2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOLOWER = 2'd2;

	// action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_CLAIM  = 1'b1;

	typedef struct packed {
		logic             action;
		logic [POS_W-1:0] position;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    distance;
		logic [TOTAL_W-1:0]  running_total;
	} out_item_t;

	// result of one item from the search and shift engine
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    distance;
	} core_res_t;

endpackage

>>> hdl/ordered_set_predecessor_claim.sv
// Ordered multiset of positions with strict-predecessor claim. An insert beat
// (action 0) stores its position in an ascending store, after equal entries;
// a claim beat (action 1) removes the greatest stored entry strictly below the
// query, reports query minus entry and adds it to a 48-bit total that
// saturates. Status is full for an insert into a full store and no-lower for a
// claim with nothing below; neither changes state. One item is handled at a
// time: a binary search over the n stored entries, then a shift of one entry
// per cycle, moving n-k entries for an insert landing at slot k and n-k-1 for
// a claim of slot k. The search has a single comparator and the store has a
// one-write, one-read port. The result sits in an output register, so the
// next item is taken while it waits. The store needs no clearing after reset.
module ordered_set_predecessor_claim #(
	parameter int unsigned CAPACITY = osp_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  osp_pkg::in_item_t  req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output osp_pkg::out_item_t rsp
);
	import osp_pkg::*;

	core_res_t            res;
	logic                 res_valid;
	logic                 res_ready;
	logic                 res_fire;
	logic                 out_valid_q;
	out_item_t            out_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [TOTAL_W:0]     sum_c;
	logic [TOTAL_W-1:0]   total_c;

	// search and shift engine
	osp_core #(
		.CAPACITY(CAPACITY)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// saturating running total
	assign sum_c   = {1'b0, total_q} + {{(TOTAL_W + 1 - POS_W){1'b0}}, res.distance};
	assign total_c = sum_c[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_c[TOTAL_W-1:0];

	assign res_ready = !out_valid_q || rsp_ready;
	assign res_fire  = res_valid && res_ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
			total_q     <= '0;
		end else begin
			if (res_fire) begin
				out_valid_q         <= 1'b1;
				out_q.status        <= res.status;
				out_q.distance      <= res.distance;
				out_q.running_total <= total_c;
				total_q             <= total_c;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

>>> hdl/osp_core.sv
// sorted store with binary search and one-entry-per-cycle shift sequencer
// depends on osp_pkg
module osp_core #(
	parameter int unsigned CAPACITY = osp_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  osp_pkg::in_item_t   req,
	output logic                res_valid,
	input  logic                res_ready,
	output osp_pkg::core_res_t  res
);
	import osp_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);
	localparam logic [CW-1:0] TWO_C = CW'(2);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_CMP,
		S_INS_SHIFT,
		S_INS_PUT,
		S_CLM_DIST,
		S_CLM_SHIFT,
		S_DONE
	} state_t;

	state_t              state_q;
	logic                act_q;
	logic [POS_W-1:0]    pos_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hi_q;
	logic [CW-1:0]       mid_q;
	logic [CW-1:0]       idx_q;
	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0]    dist_q;

	logic [POS_W-1:0]    mem [CAPACITY];
	logic [POS_W-1:0]    rd_data_q;

	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [POS_W-1:0]    wr_data;

	logic [CW-1:0]       mid_c;
	logic                go_right;
	logic                srch_more;
	logic                ins_more;
	logic                clm_more;
	logic                shift_more;
	logic [CW-1:0]       lo_m1;
	logic [CW-1:0]       cnt_m1;
	logic [CW-1:0]       idx_m1;
	logic [CW-1:0]       idx_m2;
	logic [CW-1:0]       idx_p1;
	logic [CW-1:0]       idx_p2;

	// shared compare unit and loop conditions
	assign mid_c      = lo_q + ((hi_q - lo_q) >> 1);
	assign go_right   = (act_q == ACT_CLAIM) ? (rd_data_q < pos_q) : (rd_data_q <= pos_q);
	assign lo_m1      = lo_q - ONE_C;
	assign cnt_m1     = count_q - ONE_C;
	assign idx_m1     = idx_q - ONE_C;
	assign idx_m2     = idx_q - TWO_C;
	assign idx_p1     = idx_q + ONE_C;
	assign idx_p2     = idx_q + TWO_C;
	assign srch_more  = lo_q < hi_q;
	assign ins_more   = idx_m1 > lo_q;
	assign clm_more   = idx_p1 < count_q;
	assign shift_more = idx_p2 < count_q;

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_data_q;
		unique case (state_q)
			S_SRCH: begin
				if (srch_more) begin
					rd_en   = 1'b1;
					rd_addr = mid_c[AW-1:0];
				end else if (act_q == ACT_INSERT && lo_q != count_q) begin
					rd_en   = 1'b1;
					rd_addr = cnt_m1[AW-1:0];
				end else if (act_q == ACT_CLAIM && lo_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = lo_m1[AW-1:0];
				end
			end
			S_INS_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
				if (ins_more) begin
					rd_en   = 1'b1;
					rd_addr = idx_m2[AW-1:0];
				end
			end
			S_INS_PUT: begin
				wr_en   = 1'b1;
				wr_addr = lo_q[AW-1:0];
				wr_data = pos_q;
			end
			S_CLM_DIST: begin
				if (clm_more) begin
					rd_en   = 1'b1;
					rd_addr = idx_p1[AW-1:0];
				end
			end
			S_CLM_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
				if (shift_more) begin
					rd_en   = 1'b1;
					rd_addr = idx_p2[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// sorted store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			act_q    <= ACT_INSERT;
			pos_q    <= '0;
			count_q  <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			mid_q    <= '0;
			idx_q    <= '0;
			status_q <= ST_OK;
			dist_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						act_q    <= req.action;
						pos_q    <= req.position;
						lo_q     <= '0;
						hi_q     <= count_q;
						dist_q   <= '0;
						status_q <= ST_OK;
						if (req.action == ACT_INSERT && count_q == CAP_C) begin
							status_q <= ST_FULL;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (srch_more) begin
						mid_q   <= mid_c;
						state_q <= S_CMP;
					end else if (act_q == ACT_CLAIM) begin
						if (lo_q == '0) begin
							status_q <= ST_NOLOWER;
							state_q  <= S_DONE;
						end else begin
							idx_q   <= lo_m1;
							state_q <= S_CLM_DIST;
						end
					end else if (lo_q == count_q) begin
						state_q <= S_INS_PUT;
					end else begin
						idx_q   <= count_q;
						state_q <= S_INS_SHIFT;
					end
				end
				S_CMP: begin
					if (go_right) begin
						lo_q <= mid_q + ONE_C;
					end else begin
						hi_q <= mid_q;
					end
					state_q <= S_SRCH;
				end
				S_INS_SHIFT: begin
					if (ins_more) begin
						idx_q <= idx_m1;
					end else begin
						state_q <= S_INS_PUT;
					end
				end
				S_INS_PUT: begin
					count_q <= count_q + ONE_C;
					state_q <= S_DONE;
				end
				S_CLM_DIST: begin
					dist_q <= pos_q - rd_data_q;
					if (clm_more) begin
						state_q <= S_CLM_SHIFT;
					end else begin
						count_q <= cnt_m1;
						state_q <= S_DONE;
					end
				end
				S_CLM_SHIFT: begin
					if (shift_more) begin
						idx_q <= idx_p1;
					end else begin
						count_q <= cnt_m1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready    = (state_q == S_IDLE);
	assign res_valid    = (state_q == S_DONE);
	assign res.status   = status_q;
	assign res.distance = dist_q;

endmodule

>>> hdl/osp_checker.sv
// port-level checks of the ordered set predecessor claim block, with bind
// depends on osp_pkg and ordered_set_predecessor_claim
module osp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input osp_pkg::in_item_t  req,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input osp_pkg::out_item_t rsp
);
	import osp_pkg::*;

	logic [TOTAL_W-1:0] last_total_q;

	// total of the last delivered beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			last_total_q <= rsp.running_total;
		end
	end

	// a waiting result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second item taken while busy");

	// failed items carry no distance and leave the total alone
	a_fail_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |->
			rsp.distance == '0 && rsp.running_total == last_total_q)
		else $error("failed item changed distance or total");

	// total never falls
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.running_total >= last_total_q)
		else $error("running total decreased");

	// successful results add exactly their distance unless saturated
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_OK && rsp.running_total != {TOTAL_W{1'b1}} |->
			rsp.running_total == last_total_q + {{(TOTAL_W - POS_W){1'b0}}, rsp.distance})
		else $error("running total off by more than the distance");

endmodule

bind ordered_set_predecessor_claim osp_checker u_osp_checker (.*);

>>> dv/tb_top.sv
// testbench for ordered_set_predecessor_claim: random and directed insert/claim beats
// checked against a sorted-queue predictor held in a small scoreboard class
// depends on osp_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_top;
	import osp_pkg::*;

	localparam int unsigned CAP          = CAPACITY_DEF;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam int unsigned RANDOM_ITEMS = 48;
	localparam int unsigned CYCLE_LIMIT  = 8_000_000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned TAIL_CYCLES  = 200;

	// sorted multiset predictor plus the queue of results still owed by the block
	class claim_scoreboard;
		logic [POS_W-1:0]   holes[$];
		logic [TOTAL_W-1:0] claimed_sum;
		out_item_t          owed_q[$];
		int unsigned        capacity;
		int unsigned        n_fail, n_checked, n_insert, n_claim, n_full, n_nolower, peak;

		function new(int unsigned cap);
			capacity    = cap;
			claimed_sum = '0;
		endfunction

		// work out the result of an accepted beat and update the predicted store
		function void note_request(in_item_t it);
			out_item_t        want;
			int               idx;
			logic [POS_W-1:0] gap;
			logic [TOTAL_W:0] wide_sum;
			want.status   = ST_OK;
			want.distance = '0;
			if (it.action == ACT_INSERT) begin
				n_insert++;
				if (holes.size() >= capacity) begin
					want.status = ST_FULL;
					n_full++;
				end else begin
					// lands after any equal entries
					idx = holes.size();
					for (int i = 0; i < holes.size(); i++) begin
						if (holes[i] > it.position) begin
							idx = i;
							break;
						end
					end
					holes.insert(idx, it.position);
					if (holes.size() > peak)
						peak = holes.size();
				end
			end else begin
				n_claim++;
				// greatest entry strictly below the query
				idx = -1;
				for (int i = 0; i < holes.size(); i++) begin
					if (holes[i] < it.position)
						idx = i;
					else
						break;
				end
				if (idx < 0) begin
					want.status = ST_NOLOWER;
					n_nolower++;
				end else begin
					gap = it.position - holes[idx];
					holes.delete(idx);
					want.distance = gap;
					wide_sum = {1'b0, claimed_sum} + {{(TOTAL_W + 1 - POS_W){1'b0}}, gap};
					claimed_sum = wide_sum[TOTAL_W] ? '1 : wide_sum[TOTAL_W-1:0];
				end
			end
			want.running_total = claimed_sum;
			owed_q.push_back(want);
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
			n_fail++;
		endtask

		// compare one result beat with the oldest owed result
		task check_result(out_item_t got);
			out_item_t want;
			if (owed_q.size() == 0) begin
				$display("[%0t] mismatch: result beat with nothing owed, status %0d",
					$time, got.status);
				n_fail++;
				return;
			end
			want = owed_q.pop_front();
			n_checked++;
			if (got.status !== want.status)
				report_mismatch("status", 64'(got.status), 64'(want.status));
			if (got.distance !== want.distance)
				report_mismatch("distance", 64'(got.distance), 64'(want.distance));
			if (got.running_total !== want.running_total)
				report_mismatch("running_total", 64'(got.running_total),
					64'(want.running_total));
		endtask
	endclass

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	in_item_t  req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	out_item_t rsp;

	claim_scoreboard sb = new(CAP);
	bit              quiet        = 1'b0;
	bit              hold_off_req = 1'b0;
	int unsigned     cycle_count  = 0;

	ordered_set_predecessor_claim u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed",
				cycle_count, sb.owed_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: check accepted beats, random back-pressure, one long hold-off on request
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= quiet || ($urandom_range(99) >= 20);
			end
		end
	end

	function automatic in_item_t beat_of(logic action, logic [POS_W-1:0] position);
		in_item_t it;
		it.action   = action;
		it.position = position;
		return it;
	endfunction

	// offer one beat after an optional random gap, return once it is accepted
	task automatic send_item(in_item_t it);
		while (!quiet && $urandom_range(99) < 20) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		do
			@(posedge clk);
		while (!req_ready);
		sb.note_request(it);
	endtask

	// stop offering until every owed result has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.owed_q.size() != 0);
	endtask

	// empty store, strict-below rule, duplicates, zero and extreme positions
	task automatic run_directed();
		send_item(beat_of(ACT_CLAIM, 30'd1));
		send_item(beat_of(ACT_CLAIM, 30'd0));
		send_item(beat_of(ACT_CLAIM, POS_MAX));
		send_item(beat_of(ACT_INSERT, 30'd0));
		send_item(beat_of(ACT_CLAIM, 30'd0));
		send_item(beat_of(ACT_CLAIM, 30'd1));
		send_item(beat_of(ACT_INSERT, POS_MAX));
		send_item(beat_of(ACT_CLAIM, POS_MAX));
		send_item(beat_of(ACT_INSERT, 30'd5));
		send_item(beat_of(ACT_INSERT, 30'd5));
		send_item(beat_of(ACT_INSERT, 30'd5));
		send_item(beat_of(ACT_INSERT, 30'd3));
		send_item(beat_of(ACT_CLAIM, 30'd5));
		send_item(beat_of(ACT_CLAIM, 30'd6));
		send_item(beat_of(ACT_CLAIM, 30'd6));
		send_item(beat_of(ACT_CLAIM, 30'd1000000000));
		send_item(beat_of(ACT_CLAIM, 30'd6));
		send_item(beat_of(ACT_INSERT, 30'd0));
		send_item(beat_of(ACT_CLAIM, POS_MAX));
		send_item(beat_of(ACT_INSERT, 30'd1));
		send_item(beat_of(ACT_INSERT, 30'd1000000000));
		send_item(beat_of(ACT_CLAIM, POS_MAX));
		send_item(beat_of(ACT_CLAIM, 30'd2));
		send_item(beat_of(ACT_INSERT, 30'h2AAAAAAA));
		send_item(beat_of(ACT_INSERT, 30'h15555555));
		send_item(beat_of(ACT_CLAIM, 30'h2AAAAAAB));
		send_item(beat_of(ACT_CLAIM, 30'h15555556));
	endtask

	// fill the store to capacity and hit the full case; the store is left full
	task automatic run_capacity();
		logic [POS_W-1:0] v;
		v = 30'd1 << 20;
		// ascending values keep every insert at the top of the store
		while (sb.holes.size() < CAP) begin
			send_item(beat_of(ACT_INSERT, v));
			v = v + POS_W'($urandom_range(5));
		end
		send_item(beat_of(ACT_INSERT, 30'd0));
		send_item(beat_of(ACT_INSERT, POS_MAX));
		send_item(beat_of(ACT_INSERT, 30'd1 << 21));
		// one claim in the middle, refill the hole, full again
		send_item(beat_of(ACT_CLAIM, (30'd1 << 20) + 30'd1000));
		send_item(beat_of(ACT_INSERT, POS_MAX - 30'd1));
		send_item(beat_of(ACT_INSERT, 30'd7));
	endtask

	// random beat, steered by the fill level so claims mostly find entries
	function automatic in_item_t next_random_item();
		in_item_t    it;
		int unsigned fill, insert_pct, roll;
		fill = sb.holes.size();
		insert_pct = (fill < 4) ? 80 : (fill > 96) ? 20 : 50;
		it.action = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_CLAIM;
		roll = $urandom_range(99);
		if (roll < 25)
			it.position = POS_W'($urandom_range(40, 1));
		else if (roll < 55 && fill != 0)
			it.position = POS_W'(sb.holes[$urandom_range(fill - 1)]
				+ ((it.action == ACT_CLAIM) ? $urandom_range(2) : 0));
		else if (roll < 92)
			it.position = POS_W'($urandom());
		else
			it.position = (it.action == ACT_CLAIM || $urandom_range(3) == 0) ? POS_MAX : '0;
		return it;
	endfunction

	task automatic run_random();
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 12 && n < 32);
			if (n == 4)
				hold_off_req = 1'b1;
			if (n == 40)
				wait_drained();
			send_item(next_random_item());
		end
	endtask

	// main sequence
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_drained();
		run_capacity();
		wait_drained();
		run_random();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("ran %0d inserts (%0d into a full store) and %0d claims (%0d found nothing below)",
			sb.n_insert, sb.n_full, sb.n_claim, sb.n_nolower);
		$display("store peaked at %0d of %0d entries, final total %0d, %0d results compared",
			sb.peak, CAP, sb.claimed_sum, sb.n_checked);
		if (sb.n_fail == 0 && sb.owed_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
hdl/osp_pkg.sv
hdl/osp_core.sv
hdl/ordered_set_predecessor_claim.sv
hdl/osp_checker.sv
dv/tb_top.sv
